/* rtl/mexp_pkg.sv */
package mexp_pkg;

	// Status of the shared modular reduction unit, as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} mod_stat_t;

endpackage

/* rtl/mexp_mul.sv */
module mexp_mul #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      en,
	input  logic [DATA_WIDTH-1:0]     a,
	input  logic [DATA_WIDTH-1:0]     b,
	output logic [2*DATA_WIDTH-1:0]   prod
);
	localparam int PW = 2 * DATA_WIDTH;

	logic [PW-1:0] prod_q;

	// Capture the full-width product; hold it while disabled.
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PW'(a) * PW'(b);
		end
	end

	assign prod = prod_q;

endmodule

/* rtl/mexp_mod.sv */
module mexp_mod #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [2*DATA_WIDTH-1:0]   dividend,
	input  logic [DATA_WIDTH-1:0]     divisor,
	output mexp_pkg::mod_stat_t       stat,
	output logic [DATA_WIDTH-1:0]     remainder
);
	import mexp_pkg::*;

	localparam int PW = 2 * DATA_WIDTH;
	localparam int CW = $clog2(DATA_WIDTH);

	logic [PW-1:0]         dvd_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DATA_WIDTH:0]   r1_sh;
	logic [DATA_WIDTH:0]   r2_sh;
	logic [DATA_WIDTH-1:0] r1;
	logic [DATA_WIDTH-1:0] r2;

	// Two restoring steps per cycle: shift in a dividend bit, subtract if it fits.
	always_comb begin
		r1_sh = {rem_q, dvd_q[PW-1]};
		if (r1_sh >= {1'b0, divisor}) begin
			r1 = DATA_WIDTH'(r1_sh - {1'b0, divisor});
		end else begin
			r1 = r1_sh[DATA_WIDTH-1:0];
		end
		r2_sh = {r1, dvd_q[PW-2]};
		if (r2_sh >= {1'b0, divisor}) begin
			r2 = DATA_WIDTH'(r2_sh - {1'b0, divisor});
		end else begin
			r2 = r2_sh[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DATA_WIDTH - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PW-3:0], 2'b00};
			rem_q <= r2;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign remainder = rem_q;

endmodule

/* rtl/modular_exponentiation.sv */
// A zero exponent or zero modulus skips the multiply-reduce loop and goes to the output.
// Otherwise each set exponent bit takes an accumulate step, and each bit below the
// highest set bit takes a square step.
// One item at a time: in_stall holds from accept until the result loads; each
// multiply-reduce runs on the shared reducer, retiring two remainder bits per cycle.
// Reset: arst_n asynchronous active low clears the sequencer and output valid.
module modular_exponentiation #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [DATA_WIDTH-1:0] base,
	input  logic [DATA_WIDTH-1:0] exponent,
	input  logic [DATA_WIDTH-1:0] modulus,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [DATA_WIDTH-1:0] result,
	output logic                  zero_modulus
);
	import mexp_pkg::*;

	localparam int PW = 2 * DATA_WIDTH;

	// Sequencer states.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_NEXT  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_START = 3'd3;
	localparam logic [2:0] S_RED   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	// Phase within one exponent bit: accumulate step, then square step.
	localparam logic OP_ACC = 1'b0;
	localparam logic OP_SQ  = 1'b1;

	logic [2:0]            state_q;
	logic                  ph_q;
	logic                  out_valid_q;

	logic [DATA_WIDTH-1:0] e_q;       // remaining exponent bits, LSB is current bit
	logic [DATA_WIDTH-1:0] n_q;       // modulus
	logic [DATA_WIDTH-1:0] acc_q;     // running product, final answer
	logic [DATA_WIDTH-1:0] sq_q;      // running square of the base
	logic                  zm_q;
	logic [DATA_WIDTH-1:0] result_q;
	logic                  zm_out_q;

	logic                  in_acc;
	logic                  out_free;
	logic [DATA_WIDTH-1:0] mul_a;
	logic [PW-1:0]         prod;
	logic [DATA_WIDTH-1:0] rem;
	mod_stat_t             mod_st;

	assign in_acc   = in_valid && (state_q == S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Accumulate step multiplies acc by sq; square step multiplies sq by itself.
	assign mul_a = (ph_q == OP_ACC) ? acc_q : sq_q;

	mexp_mul #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mul (
		.clk  (clk),
		.en   (state_q == S_MUL),
		.a    (mul_a),
		.b    (sq_q),
		.prod (prod)
	);

	mexp_mod #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (state_q == S_START),
		.dividend  (prod),
		.divisor   (n_q),
		.stat      (mod_st),
		.remainder (rem)
	);

	// Control: sequencer state, phase and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= OP_ACC;
			out_valid_q <= 1'b0;
		end else begin
			// Raise valid as a finished item loads; drop it once the item is taken.
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						ph_q <= OP_ACC;
						if (exponent == '0 || modulus == '0) begin
							state_q <= S_DONE;
						end else begin
							state_q <= S_NEXT;
						end
					end
				end
				S_NEXT: begin
					if (ph_q == OP_ACC) begin
						// Skip the accumulate step on a zero exponent bit.
						if (e_q[0]) begin
							state_q <= S_MUL;
						end else begin
							ph_q <= OP_SQ;
						end
					end else begin
						// No higher bits left: the last square is never needed.
						if (e_q[DATA_WIDTH-1:1] != '0) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_MUL: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_RED;
				end
				S_RED: begin
					if (mod_st.done) begin
						ph_q    <= (ph_q == OP_ACC) ? OP_SQ : OP_ACC;
						state_q <= S_NEXT;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath: operands, running values and the output register.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					e_q  <= exponent;
					n_q  <= modulus;
					sq_q <= base;
					if (exponent == '0) begin
						acc_q <= DATA_WIDTH'(1);
						zm_q  <= 1'b0;
					end else if (modulus == '0) begin
						acc_q <= '0;
						zm_q  <= 1'b1;
					end else begin
						acc_q <= DATA_WIDTH'(1);
						zm_q  <= 1'b0;
					end
				end
			end
			S_RED: begin
				if (mod_st.done) begin
					if (ph_q == OP_ACC) begin
						acc_q <= rem;
					end else begin
						sq_q <= rem;
						e_q  <= e_q >> 1;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					result_q <= acc_q;
					zm_out_q <= zm_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign result       = result_q;
	assign zero_modulus = zm_out_q;

	// The reducer only runs and finishes while the sequencer waits on it.
	a_mod_busy_in_red: assert property (@(posedge clk) disable iff (!arst_n)
		mod_st.busy |-> state_q == S_RED)
		else $error("reducer busy outside reduce state");

	a_mod_done_in_red: assert property (@(posedge clk) disable iff (!arst_n)
		mod_st.done |-> state_q == S_RED)
		else $error("reducer done outside reduce state");

	// A finished nonzero-exponent result is already reduced below the modulus.
	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && !zm_q && e_q != '0) |-> acc_q < n_q)
		else $error("final product not reduced");

	// A zero-modulus error always carries a zero result.
	a_zero_mod_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && zm_out_q) |-> result_q == '0)
		else $error("zero modulus with nonzero result");

endmodule

/* bench/modular_exponentiation_tb.sv */
`timescale 1ns / 100ps

module modular_exponentiation_tb;

	// One operand set as queued for the driver. Set drain to hold the item back
	// until every earlier result has come out of the block.
	typedef struct packed {
		logic [31:0] base;
		logic [31:0] exponent;
		logic [31:0] modulus;
		logic        drain;
	} operand_set_t;

	// One predicted result item.
	typedef struct packed {
		logic [31:0] value;
		logic        zero_mod;
	} power_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] base = '0;
	logic [31:0] exponent = '0;
	logic [31:0] modulus = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] result;
	logic        zero_modulus;

	operand_set_t pending_operands[$];
	power_t       expected_powers[$];
	operand_set_t next_set;
	power_t       want;

	logic operand_taken = 1'b0;
	int   items_accepted = 0;
	int   results_checked = 0;
	int   zero_exponents = 0;
	int   zero_moduli = 0;
	int   long_exponents = 0;
	int   error_count = 0;

	modular_exponentiation #(
		.DATA_WIDTH(32)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.base        (base),
		.exponent    (exponent),
		.modulus     (modulus),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result),
		.zero_modulus(zero_modulus)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Right-to-left square and multiply. A zero exponent returns 1 unreduced,
	// ahead of the zero modulus check; a zero modulus otherwise flags an error.
	function automatic power_t power_mod(input logic [31:0] b, input logic [31:0] e,
			input logic [31:0] n);
		logic [63:0] acc;
		logic [63:0] sq;
		power_t      p;
		int          k;
		acc = 64'd1;
		sq = {32'd0, b};
		p.zero_mod = 1'b0;
		if (e == 32'd0) begin
			p.value = 32'd1;
		end else if (n == 32'd0) begin
			p.value = 32'd0;
			p.zero_mod = 1'b1;
		end else begin
			// Stop once no set bits remain at or above the current position.
			for (k = 0; k < 32 && (e >> k) != 32'd0; k++) begin
				if (e[k])
					acc = (acc * sq) % {32'd0, n};
				sq = (sq * sq) % {32'd0, n};
			end
			p.value = acc[31:0];
		end
		return p;
	endfunction

	task automatic queue_operands(input logic [31:0] b, input logic [31:0] e,
			input logic [31:0] n, input logic drain);
		operand_set_t s;
		s.base = b;
		s.exponent = e;
		s.modulus = n;
		s.drain = drain;
		pending_operands.push_back(s);
	endtask

	// Driver: change inputs on the falling edge. Hold the payload while the
	// block stalls; once the item is taken (or nothing was offered) either
	// offer the next one or idle. Idling is suppressed for a
	// stretch of the run so back-to-back traffic is seen too.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || operand_taken) begin
			if (pending_operands.size() != 0
					&& !(pending_operands[0].drain && expected_powers.size() != 0)
					&& ((items_accepted >= 150 && items_accepted < 200)
						|| $urandom_range(99) >= 15)) begin
				next_set = pending_operands.pop_front();
				base <= next_set.base;
				exponent <= next_set.exponent;
				modulus <= next_set.modulus;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver backpressure: stall about 15 percent of the time, except in a quiet
	// window of results where the output is drained without pause.
	always @(negedge clk) begin
		if (results_checked >= 150 && results_checked < 200)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(99) < 15);
	end

	// Monitor: sample both handshakes on the rising edge. Predict on input
	// accept, check against the oldest prediction on output accept.
	always @(posedge clk) begin
		operand_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			expected_powers.push_back(power_mod(base, exponent, modulus));
			items_accepted++;
			if (exponent == 32'd0)
				zero_exponents++;
			else if (modulus == 32'd0)
				zero_moduli++;
			if (exponent[31:16] != 16'd0)
				long_exponents++;
		end
		if (out_valid && !out_stall) begin
			if (expected_powers.size() == 0) begin
				$error("result item with nothing expected: result=%h zero_modulus=%b",
					result, zero_modulus);
				error_count++;
			end else begin
				want = expected_powers.pop_front();
				if (result !== want.value) begin
					$error("result mismatch: expected %h, actual %h", want.value, result);
					error_count++;
				end
				if (zero_modulus !== want.zero_mod) begin
					$error("zero_modulus mismatch: expected %b, actual %b",
						want.zero_mod, zero_modulus);
					error_count++;
				end
			end
			results_checked++;
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [31:0] b;
		logic [31:0] e;
		logic [31:0] n;
		int          span;
		int          kind;
		int          i;

		// Directed: special cases and field extremes.
		queue_operands(32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);          // zero exponent, zero modulus
		queue_operands(32'h1234_5678, 32'd0, 32'd1, 1'b0);          // zero exponent, modulus one
		queue_operands(32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);          // zero to the zero
		queue_operands(32'd7, 32'd1, 32'd0, 1'b0);                  // zero modulus
		queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);  // zero modulus, long exponent
		queue_operands(32'hDEAD_BEEF, 32'h0000_0013, 32'd1, 1'b0);  // modulus one
		queue_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		queue_operands(32'd0, 32'd5, 32'd7, 1'b0);                  // zero base
		queue_operands(32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFB, 1'b0);  // unit base
		queue_operands(32'hFFFF_FFFF, 32'd1, 32'd13, 1'b0);         // base above modulus
		queue_operands(32'd12, 32'd1, 32'd13, 1'b0);                // base below modulus
		queue_operands(32'd13, 32'd3, 32'd13, 1'b0);                // base equal to modulus
		queue_operands(32'd3, 32'h8000_0000, 32'hFFFF_FFFB, 1'b0);  // single top bit
		queue_operands(32'hFFFF_FFFE, 32'd2, 32'h8000_0000, 1'b0);
		queue_operands(32'd2, 32'd10, 32'd1000, 1'b0);
		queue_operands(32'hAAAA_AAAA, 32'h5555_5555, 32'd2, 1'b0);
		queue_operands(32'h5555_5555, 32'hAAAA_AAAA, 32'd3, 1'b0);
		queue_operands(32'h8000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);

		// Random: mostly short exponents to bound the run, a fifth up to full
		// width. Sprinkle zero exponents, zero and tiny moduli, and edge bases.
		for (i = 0; i < 252; i++) begin
			kind = $urandom_range(99);
			b = $urandom;
			n = $urandom;
			e = $urandom;
			span = ($urandom_range(99) < 80) ? $urandom_range(1, 10) : $urandom_range(11, 32);
			if (span < 32)
				e = e & ((32'd1 << span) - 32'd1);
			e[span-1] = 1'b1;
			if (kind < 5)
				e = 32'd0;
			else if (kind < 10)
				n = 32'd0;
			else if (kind < 15)
				n = $urandom_range(1, 3);
			else if (kind < 25)
				n = $urandom_range(4, 255);
			else if (kind < 30)
				b = ($urandom_range(2) == 0) ? 32'd0 :
					($urandom_range(1) == 0) ? 32'd1 : 32'hFFFF_FFFF;
			// Drain the block fully before a couple of items.
			queue_operands(b, e, n, (i == 0) || (i == 120));
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait for every item to go in and every result to come back out.
		while (pending_operands.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_powers.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		$display("Checked %0d results from %0d items (%0d zero exponents, %0d zero moduli,",
			results_checked, items_accepted, zero_exponents, zero_moduli);
		$display("  %0d exponents wider than 16 bits), with random idling on both sides.",
			long_exponents);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Hard stop: several times the slowest legal run at full-width exponents.
	initial begin
		#25_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
rtl/mexp_pkg.sv
rtl/mexp_mul.sv
rtl/mexp_mod.sv
rtl/modular_exponentiation.sv
bench/modular_exponentiation_tb.sv
